FILE: rtl/gtt_pkg.sv
// shared constants, codes and types for the guid translation table
package gtt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_WIDTH    = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 2;

    typedef logic [ID_WIDTH-1:0] guid_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [REQ_W-1:0]    req_t;

    localparam req_t REQ_REGISTER = 2'd0;
    localparam req_t REQ_FORWARD  = 2'd1;
    localparam req_t REQ_REVERSE  = 2'd2;
    localparam req_t REQ_UNUSED   = 2'd3;

    localparam status_t ST_HIT  = 3'd0;
    localparam status_t ST_NEW  = 3'd1;
    localparam status_t ST_MISS = 3'd2;
    localparam status_t ST_FULL = 3'd3;
    localparam status_t ST_BAD  = 3'd4;

    typedef struct packed {
        guid_t   guid;
        status_t status;
    } gtt_result_t;

endpackage

FILE: rtl/gtt_core.sv
// table memory, entry counter and search sequencer of the guid translation table
module gtt_core
    import gtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  guid_t       cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        req_type,
    input  guid_t       guid_in,
    output logic        res_valid,
    input  logic        res_ready,
    output gtt_result_t res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              rev_wait_reg, rev_wait_next;
    req_t              type_reg, type_next;
    guid_t             id_reg, id_next;
    guid_t             base_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    gtt_result_t       res_reg, res_next;

    guid_t             mem [TABLE_DEPTH];
    guid_t             rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    guid_t             alloc_id;
    guid_t             rev_off;
    logic              rev_hit;
    logic              last_slot;
    gtt_result_t       nf_res;
    logic              nf_write;

    assign alloc_id  = base_reg + ID_WIDTH'(cnt_reg);
    assign rev_off   = id_reg - base_reg;
    assign rev_hit   = rev_off < ID_WIDTH'(cnt_reg);
    assign last_slot = (CNT_W'(addr_reg) + CNT_W'(1)) == cnt_reg;

    // outcome when the remote id is not stored
    always_comb
    begin
        nf_write = 1'b0;
        nf_res   = '{guid: '0, status: ST_MISS};
        if (type_reg == REQ_REGISTER)
        begin
            if (cnt_reg == CNT_W'(TABLE_DEPTH) || alloc_id == '0)
            begin
                nf_res = '{guid: '0, status: ST_FULL};
            end
            else
            begin
                nf_res   = '{guid: alloc_id, status: ST_NEW};
                nf_write = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rev_wait_next = rev_wait_reg;
        type_next     = type_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        res_next      = res_reg;
        rd_addr       = addr_reg;
        wr_en         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    type_next  = req_type;
                    id_next    = guid_in;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (id_reg == '0 || type_reg == REQ_UNUSED)
                begin
                    res_next   = '{guid: '0, status: ST_BAD};
                    state_next = S_DONE;
                end
                else if (type_reg == REQ_REVERSE)
                begin
                    if (rev_hit)
                    begin
                        rd_addr       = rev_off[ADDR_W-1:0];
                        rev_wait_next = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        res_next   = '{guid: '0, status: ST_MISS};
                        state_next = S_DONE;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    res_next   = nf_res;
                    wr_en      = nf_write;
                    cnt_next   = nf_write ? cnt_reg + CNT_W'(1) : cnt_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = '0;
                    addr_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rev_wait_reg)
                begin
                    res_next      = '{guid: rd_data_reg, status: ST_HIT};
                    rev_wait_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (rd_data_reg == id_reg)
                begin
                    res_next   = '{guid: base_reg + ID_WIDTH'(addr_reg), status: ST_HIT};
                    state_next = S_DONE;
                end
                else if (last_slot)
                begin
                    res_next   = nf_res;
                    wr_en      = nf_write;
                    cnt_next   = nf_write ? cnt_reg + CNT_W'(1) : cnt_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                    rd_addr   = addr_reg + ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rev_wait_reg <= 1'b0;
            cnt_reg      <= '0;
            base_reg     <= guid_t'(1);
        end
        else
        begin
            state_reg    <= state_next;
            rev_wait_reg <= rev_wait_next;
            cnt_reg      <= cnt_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        id_reg   <= id_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= id_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < CNT_W'(TABLE_DEPTH) && type_reg == REQ_REGISTER))
        else $error("write into a full table or by a non-register request");

    a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("entry count did not follow a table write");

    a_cnt_only_on_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> cnt_reg == $past(cnt_reg))
        else $error("entry count changed without a table write");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && !rev_wait_reg) |-> CNT_W'(addr_reg) < cnt_reg)
        else $error("search beyond stored entries");
`endif

endmodule

FILE: rtl/guid_translation_table.sv
// top level of the guid translation table: search core and output beat register
//
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   req_type, guid_in
// out       out  out_valid / out_ready guid_out, status
// cfg       in   cfg_wr_en             cfg_wr_data (first local id)
//
// an invalid request or a reverse lookup miss goes idle, look, done; a reverse hit also
// passes scan for the table read. forward lookup and register walk the stored entries
// one per cycle through the table memory read port
// one request is in work at a time; the output register lets the next beat in
// while a result waits for out_ready
// reset empties the table at once, with no clearing pass, and sets first id to 1
module guid_translation_table
    import gtt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  guid_t   cfg_wr_data,
    input  logic    in_valid,
    output logic    in_ready,
    input  req_t    req_type,
    input  guid_t   guid_in,
    output logic    out_valid,
    input  logic    out_ready,
    output guid_t   guid_out,
    output status_t status
);

    logic        res_valid;
    logic        res_ready;
    gtt_result_t res;

    logic        out_valid_reg;
    gtt_result_t out_reg;

    gtt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .guid_in     (guid_in),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign guid_out  = out_reg.guid;
    assign status    = out_reg.status;

endmodule

FILE: test/gtt_translation_checker.sv
// checker for the guid translation table: watches the channels, predicts each result, compares
module gtt_translation_checker
    import gtt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_wr_en,
    input  guid_t   cfg_wr_data,
    input  logic    in_valid,
    input  logic    in_ready,
    input  req_t    req_type,
    input  guid_t   guid_in,
    input  logic    out_valid,
    input  logic    out_ready,
    input  guid_t   guid_out,
    input  status_t status,
    input  logic    end_check,
    output int      fail_count,
    output int      outstanding,
    output int      checked
);

    guid_t       remote_tbl [TABLE_DEPTH];
    int unsigned used_slots = 0;
    guid_t       first_id = 32'd1;

    gtt_result_t pending_results [$];
    gtt_result_t want;
    int          errors = 0;
    int          checked_count = 0;
    logic        leftover_done = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // translation of one request; updates the table on a new registration
    function automatic gtt_result_t translate_request(input req_t op, input guid_t id);
        gtt_result_t r;
        guid_t       off;
        guid_t       alloc;
        int          hit_slot;
        r.guid   = '0;
        r.status = ST_BAD;
        hit_slot = -1;
        if (id != '0 && op != REQ_UNUSED)
        begin
            if (op == REQ_REVERSE)
            begin
                off = id - first_id;
                if (off < used_slots)
                begin
                    r.guid   = remote_tbl[off];
                    r.status = ST_HIT;
                end
                else
                begin
                    r.status = ST_MISS;
                end
            end
            else
            begin
                for (int k = 0; k < int'(used_slots); k++)
                begin
                    if (hit_slot < 0 && remote_tbl[k] == id)
                        hit_slot = k;
                end
                alloc = first_id + guid_t'(used_slots);
                if (hit_slot >= 0)
                begin
                    r.guid   = first_id + guid_t'(hit_slot);
                    r.status = ST_HIT;
                end
                else if (op == REQ_FORWARD)
                begin
                    r.status = ST_MISS;
                end
                else if (used_slots >= TABLE_DEPTH || alloc == '0)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    remote_tbl[used_slots] = id;
                    r.guid   = alloc;
                    r.status = ST_NEW;
                    used_slots++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            used_slots = 0;
            first_id   = 32'd1;
            outstanding <= 0;
            fail_count  <= errors;
            checked     <= checked_count;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with nothing expected: guid %h status %0d",
                                              guid_out, status));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (guid_out !== want.guid)
                        report_mismatch($sformatf("guid_out %h, expected %h", guid_out, want.guid));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                    checked_count++;
                end
            end
            if (cfg_wr_en)
                first_id = cfg_wr_data;
            if (in_valid && in_ready)
                pending_results.push_back(translate_request(req_type, guid_in));
            if (end_check && !leftover_done)
            begin
                leftover_done = 1'b1;
                if (pending_results.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              pending_results.size()));
            end
            outstanding <= pending_results.size();
            fail_count  <= errors;
            checked     <= checked_count;
        end
    end

endmodule

FILE: test/tb_guid_translation_table.sv
// testbench top for the guid translation table: clock, reset, stimulus and verdict
module tb_guid_translation_table
    import gtt_pkg::*;
();

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 88;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_wr_en = 1'b0;
    guid_t   cfg_wr_data = '0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    req_t    req_type = REQ_REGISTER;
    guid_t   guid_in = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    guid_t   guid_out;
    status_t status;
    logic    end_check = 1'b0;

    int      fail_count;
    int      outstanding;
    int      checked;

    int      stall_pct = 5;
    int      gap_pct = 10;
    int      stall_left = 0;
    int      quiet_cycles = 0;
    int      sent_count = 0;
    int      setting_count = 0;
    guid_t   cur_first_id = 32'd1;
    guid_t   used_ids [$];

    always #5 clk = ~clk;

    guid_translation_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .guid_in     (guid_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .guid_out    (guid_out),
        .status      (status)
    );

    gtt_translation_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .guid_in     (guid_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .guid_out    (guid_out),
        .status      (status),
        .end_check   (end_check),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 15);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL guid_translation_table");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input req_t op, input guid_t id);
        in_valid <= 1'b1;
        req_type <= op;
        guid_in  <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_first_id(input guid_t v);
        drain_results();
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        cur_first_id = v;
        setting_count++;
    endtask

    function automatic guid_t nonzero_id();
        guid_t id;
        id = $urandom;
        if (id == '0)
            id = 32'd1;
        return id;
    endfunction

    task automatic send_random_request(input int reg_pct);
        int    k;
        req_t  op;
        guid_t id;
        k = $urandom_range(0, 99);
        if (k < reg_pct)
        begin
            op = REQ_REGISTER;
            if (used_ids.size() != 0 && $urandom_range(0, 3) == 0)
            begin
                id = used_ids[$urandom_range(0, used_ids.size() - 1)];
            end
            else
            begin
                id = nonzero_id();
                used_ids.push_back(id);
            end
        end
        else
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
            begin
                op = REQ_FORWARD;
                if (used_ids.size() != 0 && $urandom_range(0, 3) != 0)
                    id = used_ids[$urandom_range(0, used_ids.size() - 1)];
                else
                    id = nonzero_id();
            end
            else if (k < 8)
            begin
                op = REQ_REVERSE;
                if ($urandom_range(0, 3) != 0)
                    id = cur_first_id + guid_t'($urandom_range(0, TABLE_DEPTH + 5));
                else
                    id = $urandom;
            end
            else if (k == 8)
            begin
                op = req_t'($urandom_range(0, 3));
                id = '0;
            end
            else
            begin
                op = REQ_UNUSED;
                id = $urandom;
            end
        end
        send_request(op, id);
    endtask

    initial
    begin
        guid_t phase_base [PHASES];
        int    phase_gap [PHASES];
        int    phase_stall [PHASES];

        phase_base  = '{32'h0000_1000, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'h8000_0000, 32'd0};
        phase_gap   = '{10, 5, 25, 3, 15, 0};
        phase_stall = '{8, 4, 15, 2, 10, 0};
        phase_base[5] = nonzero_id();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_first_id(32'd1);

        // empty table, then first allocations and lookups both ways
        send_request(REQ_REVERSE, 32'd5);
        send_request(REQ_FORWARD, 32'hFFFF_FFFF);
        send_request(REQ_REGISTER, 32'hFFFF_FFFF);
        send_request(REQ_REGISTER, 32'd1);
        send_request(REQ_REGISTER, 32'hFFFF_FFFF);
        send_request(REQ_FORWARD, 32'd1);
        send_request(REQ_REVERSE, 32'd1);
        send_request(REQ_REVERSE, 32'd2);
        send_request(REQ_REVERSE, 32'd3);
        // zero operand for every type, then the unused type
        send_request(REQ_REGISTER, 32'd0);
        send_request(REQ_FORWARD, 32'd0);
        send_request(REQ_REVERSE, 32'd0);
        send_request(REQ_UNUSED, 32'd0);
        send_request(REQ_UNUSED, 32'h1234_5678);
        send_request(REQ_REGISTER, 32'hAAAA_AAAA);
        send_request(REQ_REGISTER, 32'h5555_5555);
        used_ids.push_back(32'hFFFF_FFFF);
        used_ids.push_back(32'd1);
        used_ids.push_back(32'hAAAA_AAAA);
        used_ids.push_back(32'h5555_5555);

        // four slots in use: next local id wraps to zero, and old slots renumber
        set_first_id(32'hFFFF_FFFC);
        send_request(REQ_REGISTER, 32'h0BAD_F00D);
        send_request(REQ_FORWARD, 32'hFFFF_FFFF);
        send_request(REQ_REVERSE, 32'hFFFF_FFFF);
        send_request(REQ_REVERSE, 32'hFFFF_FFFE);
        send_request(REQ_REVERSE, 32'd1);

        for (int p = 0; p < PHASES; p++)
        begin
            set_first_id(phase_base[p]);
            gap_pct   = phase_gap[p];
            stall_pct <= phase_stall[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < gap_pct)
                    idle_gap($urandom_range(1, 16));
                send_random_request(p == 0 ? 80 : 30);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("run covered %0d requests and %0d checked results over %0d first-id settings,",
                 sent_count, checked, setting_count);
        $display("from an empty table to a full one, with and without idle cycles");
        if (fail_count == 0)
            $display("PASS guid_translation_table");
        else
            $display("FAIL guid_translation_table");
        $finish;
    end

endmodule
